/* design/pcq_pkg.sv */
// ----------------------------------------------------------------------------
// pcq_pkg: shared types and constants for the per-connection pending quota
// Field layouts, operation codes, register indexes and reset limits.
// ----------------------------------------------------------------------------
package pcq_pkg;

    localparam int MODE_W  = 2;
    localparam int CONN_W  = 8;
    localparam int LEN_W   = 24;
    localparam int TASK_W  = 16;
    localparam int BYTE_W  = 32;
    localparam int CFG_W   = 32;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic CFG_MAX_TASKS = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    localparam logic [TASK_W-1:0] RESET_MAX_TASKS = 16'd1024;
    localparam logic [BYTE_W-1:0] RESET_MAX_BYTES = 32'd4194304;

    typedef struct packed {
        logic [LEN_W-1:0]  data_len;
        logic [CONN_W-1:0] conn_index;
        logic [MODE_W-1:0] mode;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] bytes;
        logic [TASK_W-1:0] tasks;
    } entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_total;
        logic [TASK_W-1:0] task_count;
        logic              granted;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] max_bytes;
        logic [TASK_W-1:0] max_tasks;
    } limits_t;

endpackage

/* design/pcq_ram.sv */
// ----------------------------------------------------------------------------
// pcq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/pcq_update.sv */
// ----------------------------------------------------------------------------
// pcq_update: quota entry update
// Reserve, release and clear arithmetic on one table entry.
// ----------------------------------------------------------------------------
module pcq_update (
    input  logic [pcq_pkg::MODE_W-1:0] mode,
    input  logic [pcq_pkg::LEN_W-1:0]  data_len,
    input  pcq_pkg::limits_t           limits,
    input  pcq_pkg::entry_t            cur_entry,
    output pcq_pkg::entry_t            new_entry,
    output logic                       granted
);
    import pcq_pkg::*;

    logic [BYTE_W-1:0] len_ext;

    assign len_ext = BYTE_W'(data_len);

    always_comb begin
        new_entry = cur_entry;
        granted   = 1'b0;
        unique case (mode)
            MODE_RESERVE: begin
                if (data_len == '0) begin
                    granted = 1'b1;
                end else if (len_ext <= limits.max_bytes
                             && cur_entry.tasks < limits.max_tasks
                             && cur_entry.bytes <= limits.max_bytes - len_ext) begin
                    new_entry.tasks = cur_entry.tasks + TASK_W'(1);
                    new_entry.bytes = cur_entry.bytes + len_ext;
                    granted         = 1'b1;
                end
            end
            MODE_RELEASE: begin
                new_entry.tasks = (cur_entry.tasks != '0) ?
                                  cur_entry.tasks - TASK_W'(1) : '0;
                new_entry.bytes = (cur_entry.bytes >= len_ext) ?
                                  cur_entry.bytes - len_ext : '0;
                granted         = 1'b1;
            end
            MODE_CLEAR: begin
                new_entry = '0;
                granted   = 1'b1;
            end
            default: begin
                new_entry = cur_entry;
                granted   = 1'b0;
            end
        endcase
    end

endmodule

/* design/per_connection_pending_quota_top.sv */
// ----------------------------------------------------------------------------
// per_connection_pending_quota_top: per-connection pending task/byte quota
// Table of pending task counts and byte totals per connection, one RAM word
// per connection, updated by read-modify-write with write-to-read forwarding.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Word
// s_       in   s_tvalid/s_tready  mode, conn_index, data_len
// m_       out  m_tvalid/m_tready  granted, task_count, byte_total
// cfg_     in   cfg_we             cfg_index selects limit, cfg_wdata value
//
// One word per cycle sustained while m_tready is high outside the clearing
// pass; an accepted word's entry is read from RAM into the update stage, and
// its updated result is registered into the output register as it advances.
// After reset a clearing pass zeroes the table, one entry per cycle, with
// s_tready low; configuration writes are taken always.
// A stalled m_ side holds one word in the update stage and one in the output
// register, then drops s_tready.
// ----------------------------------------------------------------------------
module per_connection_pending_quota_top #(
    parameter int CONNECTIONS = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [1:0] mode, [9:2] conn_index, [33:10] data_len
    input  logic [pcq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] granted, [16:1] task_count, [48:17] byte_total
    output logic [pcq_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pcq_pkg::CFG_W-1:0]    cfg_wdata
);
    import pcq_pkg::*;

    localparam int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int EXT_W = (IDX_W > CONN_W) ? IDX_W : CONN_W;
    localparam int ENT_W = TASK_W + BYTE_W;
    localparam logic [16:0]      DEPTH_L  = 17'(CONNECTIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CONNECTIONS - 1);

    limits_t           limits_reg;
    logic              clr_busy_reg;
    logic [IDX_W-1:0]  clr_addr_reg;

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic              s1_in_range_reg;
    logic [IDX_W-1:0]  s1_addr_reg;

    logic              fwd_valid_reg;
    logic [IDX_W-1:0]  fwd_addr_reg;
    entry_t            fwd_data_reg;

    logic              m_valid_reg;
    result_t           m_word_reg;

    item_t             in_item;
    logic [EXT_W-1:0]  in_idx_ext;
    logic [IDX_W-1:0]  in_addr;
    logic              in_range;
    logic              accept;
    logic              out_free;
    logic              advance;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;

    entry_t            cur_entry;
    entry_t            new_entry;
    logic              upd_granted;
    result_t           result;

    assign in_item    = s_tdata[$bits(item_t)-1:0];
    assign in_idx_ext = EXT_W'(in_item.conn_index);
    assign in_addr    = in_idx_ext[IDX_W-1:0];
    assign in_range   = 17'(in_item.conn_index) < DEPTH_L;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    assign cur_entry = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ?
                       fwd_data_reg : entry_t'(ram_rdata);

    pcq_update u_update (
        .mode      (s1_item_reg.mode),
        .data_len  (s1_item_reg.data_len),
        .limits    (limits_reg),
        .cur_entry (cur_entry),
        .new_entry (new_entry),
        .granted   (upd_granted)
    );

    always_comb begin
        if (s1_in_range_reg) begin
            result.granted    = upd_granted;
            result.task_count = new_entry.tasks;
            result.byte_total = new_entry.bytes;
        end else begin
            result = '0;
        end
    end

    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = advance && s1_in_range_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = new_entry;
        end
    end

    pcq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CONNECTIONS),
        .AW    (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.max_tasks <= RESET_MAX_TASKS;
            limits_reg.max_bytes <= RESET_MAX_BYTES;
            clr_busy_reg         <= 1'b1;
            clr_addr_reg         <= '0;
            s1_valid_reg         <= 1'b0;
            fwd_valid_reg        <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_TASKS: limits_reg.max_tasks <= cfg_wdata[TASK_W-1:0];
                    CFG_MAX_BYTES: limits_reg.max_bytes <= cfg_wdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (clr_busy_reg) begin
                if (clr_addr_reg == LAST_IDX) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                fwd_valid_reg <= 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg     <= in_item;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= in_addr;
        end
        if (ram_we) begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
        if (advance) begin
            m_word_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_word_reg);

    a_clear_ends_at_last : assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg) == LAST_IDX)
        else $error("clearing pass ended early");

    a_no_result_in_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !m_valid_reg && !s1_valid_reg)
        else $error("word in flight during clearing pass");

    a_grant_within_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_in_range_reg && s1_item_reg.mode == MODE_RESERVE
        && s1_item_reg.data_len != '0 && upd_granted
        |-> new_entry.bytes <= limits_reg.max_bytes
            && new_entry.tasks <= limits_reg.max_tasks)
        else $error("granted reserve exceeds limit");

endmodule
